// ===== sv/sqvs_pkg.sv =====
// ----------------------------------------------------------------------------
// sqvs_pkg: types, constants and helper functions for sprite quad vertex setup
// Holds the request/result payload types, the sine table function and the
// shared divider request/response types.
// ----------------------------------------------------------------------------
package sqvs_pkg;

  localparam int unsigned STORE_VERTICES_DEF   = 3072;
  localparam int unsigned SINE_TABLE_DEPTH_DEF = 256;
  localparam int unsigned CFG_IDX_W            = 1;
  localparam int unsigned CFG_DATA_W           = 13;
  localparam logic [CFG_IDX_W-1:0] CFG_TEX_W   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEX_H   = 1'b1;
  localparam logic [16:0] UV_MAX               = 17'h1FFFF;
  localparam logic [63:0] HALF_PI_Q30          = 64'd1686629713;

  typedef struct packed {
    logic [11:0]        src_x;
    logic [11:0]        src_y;
    logic [12:0]        src_w;
    logic [12:0]        src_h;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0]        angle;
    logic signed [23:0] scale_x;
    logic signed [23:0] scale_y;
    logic [31:0]        origin_xy;
    logic [3:0]         uv_mode;
    logic [31:0]        color;
  } sqvs_in_t;

  typedef struct packed {
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic [31:0]        vert_color;
    logic [11:0]        slot;
    logic               flush_first;
    logic               last;
  } sqvs_out_t;

  // shared divider request/response
  typedef struct packed {
    logic        start;
    logic [13:0] num;
    logic [12:0] den;
  } sqvs_div_req_t;

  typedef struct packed {
    logic        done;
    logic [16:0] quot;
  } sqvs_div_rsp_t;

  // quarter-wave sine, Q1.15, Taylor series in Q30 (elaboration-time constants)
  function automatic logic [15:0] sine_entry(input int unsigned i, input int unsigned depth);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    x = (HALF_PI_Q30 * 64'(i)) / 64'(depth);
    x2 = (x * x) >> 30;
    term = x;
    sum = longint'(x);
    for (int n = 1; n <= 6; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if ((n % 2) == 1) sum = sum - longint'(term);
      else              sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    sine_entry = 16'((64'(sum) + 64'd16384) >> 15);
  endfunction

endpackage

// ===== sv/sprite_quad_vertex_setup_core.sv =====
// ----------------------------------------------------------------------------
// sprite_quad_vertex_setup_core: sprite to six-vertex quad expansion
// One sprite request yields six vertices (corners 0,1,2,0,2,3).
//
//   channel | signals                          | direction
//   in      | in_valid, in_ready, in_data      | request in
//   out     | out_valid, out_ready, out_data   | vertex out
//   cfg     | cfg_we, cfg_idx, cfg_data        | register write
//
// A sprite first runs a setup sequence, then each of the four corners runs the
// shared multiplier and then the shared divider twice, once for u and once for v.
// The divider takes the largest share of the time per sprite.
// Reset is synchronous; texture size registers reset to 1, fill count to 0.
// A stalled output holds the vertex; no new request is taken until all six go.
// ----------------------------------------------------------------------------
module sprite_quad_vertex_setup_core #(
  parameter int unsigned STORE_VERTICES   = sqvs_pkg::STORE_VERTICES_DEF,
  parameter int unsigned SINE_TABLE_DEPTH = sqvs_pkg::SINE_TABLE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  sqvs_pkg::sqvs_in_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output sqvs_pkg::sqvs_out_t               out_data,
  input  logic                              cfg_we,
  input  logic [sqvs_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [sqvs_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import sqvs_pkg::*;

  localparam int unsigned KW = $clog2(SINE_TABLE_DEPTH + 1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SETUP = 8'b0000_0010,
    S_MUL   = 8'b0000_0100,
    S_DIVU  = 8'b0000_1000,
    S_DIVV  = 8'b0001_0000,
    S_NEXT  = 8'b0010_0000,
    S_EMIT  = 8'b0100_0000,
    S_WAIT  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [12:0] tex_w_r, tex_h_r;
  logic [11:0] fill_r, fill_nxt;
  sqvs_in_t    req_r;
  logic [2:0]  step_r, step_nxt;      // setup / multiply micro-step
  logic [1:0]  cid_r, cid_nxt;        // corner being computed
  logic [2:0]  vid_r, vid_nxt;        // vertex being emitted
  logic        flush_r, flush_nxt;
  logic [11:0] base_r, base_nxt;

  // per-corner results
  logic signed [31:0] cx_r [4];
  logic signed [31:0] cy_r [4];
  logic [16:0]        cu_r [4];
  logic [16:0]        cv_r [4];

  // setup values
  logic signed [47:0] dw_r, dh_r;
  logic signed [63:0] lx_r, rx_r, ty_r, by_r;
  logic signed [16:0] sn_r, cs_r;
  logic signed [63:0] acc_r;
  logic signed [63:0] px_r, py_r;

  // shared 48x18 multiplier operand select (single product per cycle)
  logic signed [47:0] ma;
  logic signed [17:0] mb;
  logic signed [65:0] prod;
  logic signed [65:0] prod_r;

  // texel coordinates of corners
  logic [12:0] sx0, sy0, sw0, sh0;
  logic [13:0] tcu [4];
  logic [13:0] tcv [4];
  logic [13:0] t;

  sqvs_div_req_t dreq;
  sqvs_div_rsp_t drsp;

  sqvs_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // sine table lookup
  logic [KW-1:0] kidx, kcomp;
  logic [16:0]   s_val, c_val;

  function automatic logic [16:0] sine_at(input logic [KW-1:0] k);
    logic [16:0] r;
    r = 17'd32768;
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
      if (k == KW'(i)) r = {1'b0, sine_entry(i, SINE_TABLE_DEPTH)};
    end
    sine_at = r;
  endfunction

  assign kidx  = KW'((32'(req_r.angle[13:0]) * SINE_TABLE_DEPTH) >> 14);
  assign kcomp = KW'(SINE_TABLE_DEPTH) - kidx;
  assign s_val = sine_at(kidx);
  assign c_val = sine_at(kcomp);

  // corner texel coordinates (combinational from the held request)
  always_comb begin
    if (req_r.uv_mode[3]) begin
      sx0 = '0; sy0 = '0;
      sw0 = (tex_w_r == 13'd0) ? 13'd1 : tex_w_r;
      sh0 = (tex_h_r == 13'd0) ? 13'd1 : tex_h_r;
    end else begin
      sx0 = {1'b0, req_r.src_x}; sy0 = {1'b0, req_r.src_y};
      sw0 = req_r.src_w; sh0 = req_r.src_h;
    end
    if (req_r.uv_mode[2]) begin
      tcu[0] = 14'(sx0) + 14'(sh0); tcv[0] = 14'(sy0);
      tcu[1] = 14'(sx0) + 14'(sh0); tcv[1] = 14'(sy0) + 14'(sw0);
      tcu[2] = 14'(sx0);            tcv[2] = 14'(sy0) + 14'(sw0);
      tcu[3] = 14'(sx0);            tcv[3] = 14'(sy0);
    end else begin
      tcu[0] = 14'(sx0);            tcv[0] = 14'(sy0);
      tcu[1] = 14'(sx0) + 14'(sw0); tcv[1] = 14'(sy0);
      tcu[2] = 14'(sx0) + 14'(sw0); tcv[2] = 14'(sy0) + 14'(sh0);
      tcu[3] = 14'(sx0);            tcv[3] = 14'(sy0) + 14'(sh0);
    end
    if (req_r.uv_mode[0]) begin
      t = tcu[0]; tcu[0] = tcu[1]; tcu[1] = t; t = tcv[0]; tcv[0] = tcv[1]; tcv[1] = t;
      t = tcu[3]; tcu[3] = tcu[2]; tcu[2] = t; t = tcv[3]; tcv[3] = tcv[2]; tcv[2] = t;
    end
    if (req_r.uv_mode[1]) begin
      t = tcu[0]; tcu[0] = tcu[3]; tcu[3] = t; t = tcv[0]; tcv[0] = tcv[3]; tcv[3] = t;
      t = tcu[1]; tcu[1] = tcu[2]; tcu[2] = t; t = tcv[1]; tcv[1] = tcv[2]; tcv[2] = t;
    end
    // texture rows run opposite to screen y
    t = tcu[0]; tcu[0] = tcu[3]; tcu[3] = t; t = tcv[0]; tcv[0] = tcv[3]; tcv[3] = t;
    t = tcu[1]; tcu[1] = tcu[2]; tcu[2] = t; t = tcv[1]; tcv[1] = tcv[2]; tcv[2] = t;
  end

  // corner offset for current corner
  logic signed [63:0] kx, ky;
  assign kx = (cid_r == 2'd0 || cid_r == 2'd3) ? lx_r : rx_r;
  assign ky = (cid_r == 2'd0 || cid_r == 2'd1) ? ty_r : by_r;

  logic signed [16:0] ox, oy;
  assign ox = 17'(signed'(req_r.origin_xy[15:0]));
  assign oy = 17'(signed'(req_r.origin_xy[31:16]));

  // multiplier operand schedule
  // setup: 0 dw=scx*sw, 1 dh=scy*sh, 2 lx, 3 rx, 4 ty, 5 by
  // corner: 0 kx*cs, 1 ky*sn, 2 kx*sn, 3 ky*cs
  always_comb begin
    ma = '0; mb = '0;
    if (state_r == S_SETUP) begin
      case (step_r)
        3'd0: begin ma = 48'(req_r.scale_x); mb = 18'(signed'({1'b0, sw0})); end
        3'd1: begin ma = 48'(req_r.scale_y); mb = 18'(signed'({1'b0, sh0})); end
        3'd2: begin ma = dw_r; mb = -18'(ox); end
        3'd3: begin ma = dw_r; mb = 18'sd16384 - 18'(ox); end
        3'd4: begin ma = dh_r; mb = -18'(oy); end
        3'd5: begin ma = dh_r; mb = 18'sd16384 - 18'(oy); end
        default: begin ma = '0; mb = '0; end
      endcase
    end else begin
      case (step_r)
        3'd0: begin ma = 48'(kx); mb = 18'(cs_r); end
        3'd1: begin ma = 48'(ky); mb = 18'(sn_r); end
        3'd2: begin ma = 48'(kx); mb = 18'(sn_r); end
        3'd3: begin ma = 48'(ky); mb = 18'(cs_r); end
        default: begin ma = '0; mb = '0; end
      endcase
    end
  end

  assign prod = 66'(ma) * 66'(mb);

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647)       sat32 = 32'sh7FFF_FFFF;
    else if (v < -66'sd2147483648) sat32 = 32'sh8000_0000;
    else                           sat32 = v[31:0];
  endfunction

  logic [12:0] fill_plus;
  assign fill_plus = 13'(fill_r) + 13'd6;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cid_nxt   = cid_r;
    vid_nxt   = vid_r;
    fill_nxt  = fill_r;
    flush_nxt = flush_r;
    base_nxt  = base_r;
    dreq      = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_SETUP;
          step_nxt  = '0;
        end
      end
      S_SETUP: begin
        // step 6 absorbs the last product; step 7 latches sin/cos and slot
        if (step_r == 3'd7) begin
          if (32'(fill_plus) > STORE_VERTICES) begin
            flush_nxt = 1'b1;
            base_nxt  = '0;
          end else begin
            flush_nxt = 1'b0;
            base_nxt  = fill_r;
          end
          state_nxt = S_MUL;
          step_nxt  = '0;
          cid_nxt   = '0;
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end
      S_MUL: begin
        if (step_r == 3'd5) begin
          state_nxt  = S_DIVU;
          dreq.start = 1'b1;
          dreq.num   = tcu[cid_r];
          dreq.den   = tex_w_r;
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end
      S_DIVU: begin
        if (drsp.done) begin
          state_nxt  = S_DIVV;
          dreq.start = 1'b1;
          dreq.num   = tcv[cid_r];
          dreq.den   = tex_h_r;
        end
      end
      S_DIVV: begin
        if (drsp.done) state_nxt = S_NEXT;
      end
      S_NEXT: begin
        if (cid_r == 2'd3) begin
          state_nxt = S_EMIT;
          vid_nxt   = '0;
        end else begin
          cid_nxt   = cid_r + 2'd1;
          step_nxt  = '0;
          state_nxt = S_MUL;
        end
      end
      S_EMIT: begin
        if (out_ready) begin
          if (vid_r == 3'd5) begin
            state_nxt = S_WAIT;
            fill_nxt  = base_r + 12'd6;
          end else begin
            vid_nxt = vid_r + 3'd1;
          end
        end
      end
      S_WAIT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      tex_w_r <= 13'd1;
      tex_h_r <= 13'd1;
      fill_r  <= '0;
      step_r  <= '0;
      cid_r   <= '0;
      vid_r   <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      step_r  <= step_nxt;
      cid_r   <= cid_nxt;
      vid_r   <= vid_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          CFG_TEX_W: tex_w_r <= cfg_data;
          CFG_TEX_H: tex_h_r <= cfg_data;
          default: ;
        endcase
      end
    end
    flush_r <= flush_nxt;
    base_r  <= base_nxt;
    prod_r  <= prod;
    if (state_r == S_IDLE && in_valid) req_r <= in_data;
    if (state_r == S_SETUP) begin
      case (step_r)
        3'd1: dw_r <= prod_r[47:0];
        3'd2: dh_r <= prod_r[47:0];
        3'd3: lx_r <= $signed(prod_r[63:0]) >>> 14;
        3'd4: rx_r <= $signed(prod_r[63:0]) >>> 14;
        3'd5: ty_r <= $signed(prod_r[63:0]) >>> 14;
        3'd6: by_r <= $signed(prod_r[63:0]) >>> 14;
        3'd7: begin
          px_r <= 64'(req_r.pos_x);
          py_r <= 64'(req_r.pos_y);
          case (req_r.angle[15:14])
            2'd0: begin sn_r <= s_val;  cs_r <= c_val;  end
            2'd1: begin sn_r <= c_val;  cs_r <= -s_val; end
            2'd2: begin sn_r <= -s_val; cs_r <= -c_val; end
            default: begin sn_r <= -c_val; cs_r <= s_val; end
          endcase
        end
        default: ;
      endcase
    end
    if (state_r == S_MUL) begin
      case (step_r)
        3'd1: acc_r <= prod_r[63:0];
        3'd2: cx_r[cid_r] <= sat32(66'((acc_r - $signed(prod_r[63:0])) >>> 15)
                                   + 66'(px_r));
        3'd3: acc_r <= prod_r[63:0];
        3'd4: cy_r[cid_r] <= sat32(66'((acc_r + $signed(prod_r[63:0])) >>> 15)
                                   + 66'(py_r));
        default: ;
      endcase
    end
    if (state_r == S_DIVU && drsp.done)
      cu_r[cid_r] <= drsp.quot;
    if (state_r == S_DIVV && drsp.done)
      cv_r[cid_r] <= drsp.quot;
  end

  logic [1:0] qsel;
  always_comb begin
    case (vid_r)
      3'd0: qsel = 2'd0;
      3'd1: qsel = 2'd1;
      3'd2: qsel = 2'd2;
      3'd3: qsel = 2'd0;
      3'd4: qsel = 2'd2;
      default: qsel = 2'd3;
    endcase
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_EMIT);
  always_comb begin
    out_data.vert_x      = cx_r[qsel];
    out_data.vert_y      = cy_r[qsel];
    out_data.tex_u       = cu_r[qsel];
    out_data.tex_v       = cv_r[qsel];
    out_data.vert_color  = req_r.color;
    out_data.slot        = base_r + 12'(vid_r);
    out_data.flush_first = flush_r && (vid_r == 3'd0);
    out_data.last        = (vid_r == 3'd5);
  end

`ifndef SYNTHESIS
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("state not one-hot");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("request taken while emitting");
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill_r) <= STORE_VERTICES) else $error("fill count beyond store");
  a_fill_adv: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_data.last) |=> fill_r == $past(base_r) + 12'd6)
    else $error("fill count not advanced");
`endif
endmodule

// ===== sv/sqvs_divider.sv =====
// ----------------------------------------------------------------------------
// sqvs_divider: shared restoring divider
// Computes min(floor(num * 65536 / den), UV_MAX), one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sqvs_divider (
  input  logic                   clk,
  input  logic                   rst_n,
  input  sqvs_pkg::sqvs_div_req_t req,
  output sqvs_pkg::sqvs_div_rsp_t rsp
);
  import sqvs_pkg::*;

  // dividend num<<16 is 30 bits; quotient bits 17 and up only flag saturation
  logic [29:0] dvd_r, dvd_nxt;
  logic [13:0] rem_r, rem_nxt;
  logic [12:0] den_r, den_nxt;
  logic [29:0] quo_r, quo_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [13:0] trial;
  logic [14:0] diff;

  assign trial = {rem_r[12:0], dvd_r[29]};
  assign diff  = {1'b0, trial} - {2'b00, den_r};

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      dvd_nxt  = {req.num, 16'd0};
      rem_nxt  = '0;
      den_nxt  = (req.den == 13'd0) ? 13'd1 : req.den;
      quo_nxt  = '0;
      cnt_nxt  = 5'd29;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[28:0], 1'b0};
      if (!diff[14]) begin
        rem_nxt = diff[13:0];
        quo_nxt = {quo_r[28:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[28:0], 1'b0};
      end
      if (cnt_r == 5'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = (quo_r[29:17] != 13'd0) ? UV_MAX : quo_r[16:0];

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !req.start) else $error("divider restarted while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("done held for two cycles");
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> rem_r < {1'b0, den_r}) else $error("remainder not below divisor");
`endif
endmodule
